[sv/tpr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_pkg
// shared widths, register indexes and the arctangent table of the tilt core
// ----------------------------------------------------------------------------
package tpr_pkg;

	localparam int ADC_BITS         = 10;
	localparam int FS_BITS          = 13;
	localparam int ACC_BITS         = 16;
	localparam int ANG_BITS         = 15;
	localparam int ANGLE_ITERATIONS = 16;
	localparam int TABLE_SIZE       = 24;
	localparam int ANGLE_LIMIT      = 11520;

	// divider: dividend magnitude bits, remainder bits
	localparam int DIV_BITS = 2 * ADC_BITS + FS_BITS + 2;
	localparam int DEN_BITS = ADC_BITS + 1;

	// square root: radicand and root widths
	localparam int SQ_BITS   = 2 * ACC_BITS;
	localparam int RAD_BITS  = SQ_BITS + 16;
	localparam int ROOT_BITS = RAD_BITS / 2;
	localparam int REM_BITS  = ROOT_BITS + 2;

	// vectoring datapath
	localparam int VEC_BITS = ROOT_BITS + 3;
	localparam int Z_BITS   = 25;
	localparam int SH_BITS  = 5;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = FS_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_X_LOW      = 3'd0,
		REG_X_HIGH     = 3'd1,
		REG_Y_LOW      = 3'd2,
		REG_Y_HIGH     = 3'd3,
		REG_Z_LOW      = 3'd4,
		REG_Z_HIGH     = 3'd5,
		REG_FULL_SCALE = 3'd6
	} cfg_reg_t;

	// atan(2^-i) in 2^-16 degree
	localparam logic signed [Z_BITS-1:0] ATAN_TBL [TABLE_SIZE] = '{
		25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
		25'sd234379, 25'sd117304, 25'sd58666, 25'sd29335,
		25'sd14668, 25'sd7334, 25'sd3667, 25'sd1833,
		25'sd917, 25'sd458, 25'sd229, 25'sd115,
		25'sd57, 25'sd29, 25'sd14, 25'sd7,
		25'sd4, 25'sd2, 25'sd1, 25'sd0
	};

endpackage

[sv/tpr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_in_if / tpr_out_if
// valid/ready channels for raw samples and tilt results
// ----------------------------------------------------------------------------
interface tpr_in_if;
	logic                         valid;
	logic                         ready;
	logic [tpr_pkg::ADC_BITS-1:0] raw_x;
	logic [tpr_pkg::ADC_BITS-1:0] raw_y;
	logic [tpr_pkg::ADC_BITS-1:0] raw_z;

	modport source (output valid, raw_x, raw_y, raw_z, input ready);
	modport sink (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface tpr_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [tpr_pkg::ACC_BITS-1:0] accel_x;
	logic signed [tpr_pkg::ACC_BITS-1:0] accel_y;
	logic signed [tpr_pkg::ACC_BITS-1:0] accel_z;
	logic signed [tpr_pkg::ANG_BITS-1:0] pitch;
	logic signed [tpr_pkg::ANG_BITS-1:0] roll;
	logic                                calibration_fault;

	modport source (output valid, accel_x, accel_y, accel_z, pitch, roll,
		calibration_fault, input ready);
	modport sink (input valid, accel_x, accel_y, accel_z, pitch, roll,
		calibration_fault, output ready);
endinterface

[sv/tpr_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_div_cell
// one quotient bit of a restoring divider
// ----------------------------------------------------------------------------
module tpr_div_cell (
	input  logic                         clk,
	input  logic                         en,
	input  logic [tpr_pkg::DEN_BITS-1:0] den,
	input  logic [tpr_pkg::DIV_BITS-1:0] u_in,
	input  logic [tpr_pkg::DEN_BITS-1:0] rem_in,
	input  logic [tpr_pkg::DIV_BITS-1:0] q_in,
	input  logic                         neg_in,
	output logic [tpr_pkg::DIV_BITS-1:0] u_q,
	output logic [tpr_pkg::DEN_BITS-1:0] rem_q,
	output logic [tpr_pkg::DIV_BITS-1:0] q_q,
	output logic                         neg_q
);

	logic [tpr_pkg::DEN_BITS:0] trial;
	logic                       ge;

	assign trial = {rem_in, u_in[tpr_pkg::DIV_BITS-1]};
	assign ge    = (trial >= {1'b0, den});

	always_ff @(posedge clk) begin
		if (en) begin
			u_q   <= {u_in[tpr_pkg::DIV_BITS-2:0], 1'b0};
			rem_q <= ge ? tpr_pkg::DEN_BITS'(trial - {1'b0, den})
				: trial[tpr_pkg::DEN_BITS-1:0];
			q_q   <= {q_in[tpr_pkg::DIV_BITS-2:0], ge};
			neg_q <= neg_in;
		end
	end

endmodule

[sv/tpr_sqrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_sqrt_cell
// one root bit of a digit-by-digit integer square root
// ----------------------------------------------------------------------------
module tpr_sqrt_cell (
	input  logic                          clk,
	input  logic                          en,
	input  logic [tpr_pkg::RAD_BITS-1:0]  rad_in,
	input  logic [tpr_pkg::REM_BITS-1:0]  rem_in,
	input  logic [tpr_pkg::ROOT_BITS-1:0] root_in,
	output logic [tpr_pkg::RAD_BITS-1:0]  rad_q,
	output logic [tpr_pkg::REM_BITS-1:0]  rem_q,
	output logic [tpr_pkg::ROOT_BITS-1:0] root_q
);

	logic [tpr_pkg::REM_BITS+1:0] rem_t;
	logic [tpr_pkg::REM_BITS+1:0] trial;
	logic                         ge;

	assign rem_t = {rem_in, rad_in[tpr_pkg::RAD_BITS-1 -: 2]};
	assign trial = {2'b00, root_in, 2'b01};
	assign ge    = (rem_t >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad_in[tpr_pkg::RAD_BITS-3:0], 2'b00};
			rem_q  <= ge ? tpr_pkg::REM_BITS'(rem_t - trial) : rem_t[tpr_pkg::REM_BITS-1:0];
			root_q <= {root_in[tpr_pkg::ROOT_BITS-2:0], ge};
		end
	end

endmodule

[sv/tpr_cordic_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tpr_cordic_cell
// one vectoring rotation step, driving y toward zero
// ----------------------------------------------------------------------------
module tpr_cordic_cell (
	input  logic                                clk,
	input  logic                                en,
	input  logic [tpr_pkg::SH_BITS-1:0]         shift,
	input  logic signed [tpr_pkg::Z_BITS-1:0]   atan,
	input  logic signed [tpr_pkg::VEC_BITS-1:0] x_in,
	input  logic signed [tpr_pkg::VEC_BITS-1:0] y_in,
	input  logic signed [tpr_pkg::Z_BITS-1:0]   z_in,
	input  logic                                zero_in,
	output logic signed [tpr_pkg::VEC_BITS-1:0] x_q,
	output logic signed [tpr_pkg::VEC_BITS-1:0] y_q,
	output logic signed [tpr_pkg::Z_BITS-1:0]   z_q,
	output logic                                zero_q
);

	logic signed [tpr_pkg::VEC_BITS-1:0] dx;
	logic signed [tpr_pkg::VEC_BITS-1:0] dy;
	logic                                pos;

	// arithmetic shifts round toward minus infinity
	assign dx  = y_in >>> shift;
	assign dy  = x_in >>> shift;
	assign pos = (y_in > 0);

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= pos ? x_in + dx : x_in - dx;
			y_q    <= pos ? y_in - dy : y_in + dy;
			z_q    <= pos ? z_in + atan : z_in - atan;
			zero_q <= zero_in;
		end
	end

endmodule

[sv/accel_tilt_pitch_roll_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_pitch_roll_core
// raw three-axis samples to calibrated acceleration, pitch and roll
// ----------------------------------------------------------------------------
//  channel  | dir | handshake     | content
//  in_ch    | in  | valid/ready   | raw_x, raw_y, raw_z
//  out_ch   | out | valid/ready   | accel_x/y/z, pitch, roll, calibration_fault
//  cfg      | in  | cfg_we        | cfg_index, cfg_data (seven calibration regs)
//
//  one item per cycle while no result waits at the output; the chain of cells:
//  2 map stages, 35 divider cells, 3 scaling/square stages, 24 root cells,
//  16 rotation cells and the output register
//  reset clears the valid line and loads the calibration defaults
//  a result waiting at the output holds every stage; bubbles do not collapse
// ----------------------------------------------------------------------------
module accel_tilt_pitch_roll_core (
	input  logic                              clk,
	input  logic                              arst_n,
	tpr_in_if.sink                            in_ch,
	tpr_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [tpr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [tpr_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	localparam int AB    = tpr_pkg::ADC_BITS;
	localparam int FB    = tpr_pkg::FS_BITS;
	localparam int DB    = tpr_pkg::DIV_BITS;
	localparam int NB    = tpr_pkg::DEN_BITS;
	localparam int PB    = AB + FB + 2;
	localparam int SQRTN = tpr_pkg::ROOT_BITS;
	localparam int ITER  = tpr_pkg::ANGLE_ITERATIONS;
	localparam int DEPTH = 2 + DB + 3 + SQRTN + ITER;
	localparam int ADLY  = 2 + SQRTN + ITER;
	localparam int VB    = tpr_pkg::VEC_BITS;
	localparam int ZB    = tpr_pkg::Z_BITS;

	typedef logic signed [tpr_pkg::ACC_BITS-1:0] acc_t;
	typedef struct packed {
		acc_t x;
		acc_t y;
		acc_t z;
	} acc3_t;

	// calibration registers
	logic [AB-1:0] lo_q [3];
	logic [AB-1:0] hi_q [3];
	logic [FB-1:0] fs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				lo_q[k] <= '0;
				hi_q[k] <= '1;
			end
			fs_q <= FB'(7534);
		end else if (cfg_we) begin
			case (tpr_pkg::cfg_reg_t'(cfg_index))
				tpr_pkg::REG_X_LOW:      lo_q[0] <= cfg_data[AB-1:0];
				tpr_pkg::REG_X_HIGH:     hi_q[0] <= cfg_data[AB-1:0];
				tpr_pkg::REG_Y_LOW:      lo_q[1] <= cfg_data[AB-1:0];
				tpr_pkg::REG_Y_HIGH:     hi_q[1] <= cfg_data[AB-1:0];
				tpr_pkg::REG_Z_LOW:      lo_q[2] <= cfg_data[AB-1:0];
				tpr_pkg::REG_Z_HIGH:     hi_q[2] <= cfg_data[AB-1:0];
				tpr_pkg::REG_FULL_SCALE: fs_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// span per axis; bad spans only matter through the fault flag
	logic [NB-1:0] den [3];
	logic          fault;

	always_comb begin
		fault = 1'b0;
		for (int k = 0; k < 3; k++) begin
			den[k] = {AB'(hi_q[k] - lo_q[k]), 1'b0};
			if (hi_q[k] <= lo_q[k])
				fault = 1'b1;
		end
	end

	// global advance: every stage moves unless a result is stuck at the output
	logic             en;
	logic [DEPTH-1:0] vld_q;
	logic             out_v_q;

	assign en          = !out_v_q || out_ch.ready;
	assign in_ch.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			out_v_q <= 1'b0;
		end else if (en) begin
			vld_q   <= {vld_q[DEPTH-2:0], in_ch.valid};
			out_v_q <= vld_q[DEPTH-1];
		end
	end

	// map stage 1: (raw - low) * full_scale
	logic [AB-1:0]        raw [3];
	logic signed [PB-1:0] prod_s1 [3];

	assign raw[0] = in_ch.raw_x;
	assign raw[1] = in_ch.raw_y;
	assign raw[2] = in_ch.raw_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++)
				prod_s1[k] <= PB'($signed({1'b0, raw[k]}) - $signed({1'b0, lo_q[k]}))
					* $signed({1'b0, fs_q});
		end
	end

	// map stage 2: rounding numerator, folded to a magnitude for floor division
	logic signed [PB+1:0] num [3];
	logic [DB-1:0]        u_s2 [3];
	logic                 neg_s2 [3];

	always_comb begin
		for (int k = 0; k < 3; k++)
			num[k] = $signed({prod_s1[k], 2'b00}) + $signed({1'b0, den[k][NB-1:1]});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				neg_s2[k] <= num[k][PB+1];
				u_s2[k]   <= num[k][PB+1]
					? DB'(-num[k] + $signed({1'b0, den[k]}) - 1)
					: DB'(num[k]);
			end
		end
	end

	// divider chains, one quotient bit per cell
	logic [DB-1:0] du  [3][DB+1];
	logic [NB-1:0] dr  [3][DB+1];
	logic [DB-1:0] dq  [3][DB+1];
	logic          dn  [3][DB+1];

	for (genvar a = 0; a < 3; a++) begin : g_axis
		assign du[a][0] = u_s2[a];
		assign dr[a][0] = '0;
		assign dq[a][0] = '0;
		assign dn[a][0] = neg_s2[a];
		for (genvar c = 0; c < DB; c++) begin : g_div
			tpr_div_cell u_cell (
				.clk    (clk),
				.en     (en),
				.den    (den[a]),
				.u_in   (du[a][c]),
				.rem_in (dr[a][c]),
				.q_in   (dq[a][c]),
				.neg_in (dn[a][c]),
				.u_q    (du[a][c+1]),
				.rem_q  (dr[a][c+1]),
				.q_q    (dq[a][c+1]),
				.neg_q  (dn[a][c+1])
			);
		end
	end

	// restore sign, remove the offset and saturate to 16 bits
	acc3_t                sat_s;
	logic signed [DB+2:0] lin [3];
	acc_t                 acc_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			lin[k] = dn[k][DB] ? -$signed({2'b00, dq[k][DB]}) : $signed({2'b00, dq[k][DB]});
			lin[k] = lin[k] - $signed({1'b0, fs_q});
			if (lin[k] > 32767)
				acc_c[k] = 16'sh7fff;
			else if (lin[k] < -32768)
				acc_c[k] = 16'sh8000;
			else
				acc_c[k] = lin[k][15:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s.x <= acc_c[0];
			sat_s.y <= acc_c[1];
			sat_s.z <= acc_c[2];
		end
	end

	// accelerations ride alongside the root and rotation cells
	acc3_t acc_dl [ADLY];

	always_ff @(posedge clk) begin
		if (en) begin
			acc_dl[0] <= sat_s;
			for (int k = 1; k < ADLY; k++)
				acc_dl[k] <= acc_dl[k-1];
		end
	end

	// squares, then radicands scaled by 2^16
	logic [tpr_pkg::SQ_BITS-1:0]  sqx_s, sqy_s, sqz_s;
	logic [tpr_pkg::RAD_BITS-1:0] radp_s, radr_s;

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s  <= tpr_pkg::SQ_BITS'(sat_s.x * sat_s.x);
			sqy_s  <= tpr_pkg::SQ_BITS'(sat_s.y * sat_s.y);
			sqz_s  <= tpr_pkg::SQ_BITS'(sat_s.z * sat_s.z);
			radp_s <= {tpr_pkg::SQ_BITS'(sqy_s + sqz_s), 16'h0000};
			radr_s <= {tpr_pkg::SQ_BITS'(sqx_s + sqz_s), 16'h0000};
		end
	end

	// two root chains: [0] pitch, [1] roll
	logic [tpr_pkg::RAD_BITS-1:0]  sr_rad  [2][SQRTN+1];
	logic [tpr_pkg::REM_BITS-1:0]  sr_rem  [2][SQRTN+1];
	logic [tpr_pkg::ROOT_BITS-1:0] sr_root [2][SQRTN+1];

	assign sr_rad[0][0] = radp_s;
	assign sr_rad[1][0] = radr_s;

	// rotation chains
	logic signed [VB-1:0] cx [2][ITER+1];
	logic signed [VB-1:0] cy [2][ITER+1];
	logic signed [ZB-1:0] cz [2][ITER+1];
	logic                 cn [2][ITER+1];
	acc_t                 num_a [2];

	assign num_a[0] = acc_dl[SQRTN+1].x;
	assign num_a[1] = acc_dl[SQRTN+1].y;

	for (genvar p = 0; p < 2; p++) begin : g_ang
		assign sr_rem[p][0]  = '0;
		assign sr_root[p][0] = '0;
		for (genvar c = 0; c < SQRTN; c++) begin : g_sqrt
			tpr_sqrt_cell u_cell (
				.clk     (clk),
				.en      (en),
				.rad_in  (sr_rad[p][c]),
				.rem_in  (sr_rem[p][c]),
				.root_in (sr_root[p][c]),
				.rad_q   (sr_rad[p][c+1]),
				.rem_q   (sr_rem[p][c+1]),
				.root_q  (sr_root[p][c+1])
			);
		end

		// start vector (r, 256*a)
		assign cx[p][0] = $signed({3'b000, sr_root[p][SQRTN]});
		assign cy[p][0] = $signed({{3{num_a[p][15]}}, num_a[p], 8'h00});
		assign cz[p][0] = '0;
		assign cn[p][0] = (sr_root[p][SQRTN] == '0) && (num_a[p] == '0);

		for (genvar c = 0; c < ITER; c++) begin : g_rot
			tpr_cordic_cell u_cell (
				.clk     (clk),
				.en      (en),
				.shift   (tpr_pkg::SH_BITS'(c)),
				.atan    (tpr_pkg::ATAN_TBL[c]),
				.x_in    (cx[p][c]),
				.y_in    (cy[p][c]),
				.z_in    (cz[p][c]),
				.zero_in (cn[p][c]),
				.x_q     (cx[p][c+1]),
				.y_q     (cy[p][c+1]),
				.z_q     (cz[p][c+1]),
				.zero_q  (cn[p][c+1])
			);
		end
	end

	// round to 1/128 degree and clamp to +-90 degrees
	logic signed [ZB:0]     zr  [2];
	logic signed [ZB-9:0]   zd  [2];
	logic signed [tpr_pkg::ANG_BITS-1:0] ang [2];

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			zr[k] = (ZB+1)'(cz[k][ITER]) + (ZB+1)'(256);
			zd[k] = (ZB-8)'(zr[k] >>> 9);
			if (cn[k][ITER])
				ang[k] = '0;
			else if (zd[k] > tpr_pkg::ANGLE_LIMIT)
				ang[k] = tpr_pkg::ANG_BITS'(tpr_pkg::ANGLE_LIMIT);
			else if (zd[k] < -tpr_pkg::ANGLE_LIMIT)
				ang[k] = -tpr_pkg::ANG_BITS'(tpr_pkg::ANGLE_LIMIT);
			else
				ang[k] = zd[k][tpr_pkg::ANG_BITS-1:0];
		end
	end

	// output register; a bad calibration zeroes every data field and sets the fault flag
	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.accel_x           <= fault ? '0 : acc_dl[ADLY-1].x;
			out_ch.accel_y           <= fault ? '0 : acc_dl[ADLY-1].y;
			out_ch.accel_z           <= fault ? '0 : acc_dl[ADLY-1].z;
			out_ch.pitch             <= fault ? '0 : ang[0];
			out_ch.roll              <= fault ? '0 : ang[1];
			out_ch.calibration_fault <= fault;
		end
	end

	assign out_ch.valid = out_v_q;

endmodule
